// File: sv/r2h_pkg.sv
// shared types and constants for the rgb to hsv converter
package r2h_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumerW = 16;
  localparam int unsigned RecipW = NumerW + 1;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pix_req_t;

  typedef struct packed {
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } hsv_res_t;

  typedef enum logic [1:0] {
    SecRed,
    SecGreen,
    SecBlue
  } sector_e;

  // clock enables of the two register stages inside one submodule
  typedef struct packed {
    logic s0;
    logic s1;
  } stage_en_t;

endpackage

// File: sv/r2h_prep.sv
// max/min, sector and numerator stages with reciprocal lookup
module r2h_prep (
  input  logic                            clk_i,
  input  r2h_pkg::stage_en_t              en_i,
  input  r2h_pkg::pix_req_t               pix_i,
  output logic [r2h_pkg::NumerW-1:0]      hue_num_o,
  output logic [r2h_pkg::ChanW-1:0]       hue_den_o,
  output logic [r2h_pkg::RecipW-1:0]      hue_recip_o,
  output logic                            hue_zero_o,
  output logic [r2h_pkg::NumerW-1:0]      sat_num_o,
  output logic [r2h_pkg::ChanW-1:0]       sat_den_o,
  output logic [r2h_pkg::RecipW-1:0]      sat_recip_o,
  output logic                            sat_zero_o
);

  // floor(2^16 / m), entry zero unused
  logic [r2h_pkg::RecipW-1:0] recip_tbl [256];

  assign recip_tbl[0] = '0;
  for (genvar i = 1; i < 256; i++) begin : g_recip
    localparam logic [r2h_pkg::RecipW-1:0] RecipVal = r2h_pkg::RecipW'(65536 / i);
    assign recip_tbl[i] = RecipVal;
  end

  // stage 0: max, min and sector
  logic [7:0]       mx_d, mn_d, delta_d;
  logic signed [8:0] diff_d;
  r2h_pkg::sector_e sec_d;

  logic [7:0]       mx_q, delta_q;
  logic [8:0]       diff_q;
  r2h_pkg::sector_e sec_q;

  always_comb begin
    mx_d = pix_i.red;
    if (pix_i.green > mx_d) mx_d = pix_i.green;
    if (pix_i.blue > mx_d) mx_d = pix_i.blue;
    mn_d = pix_i.red;
    if (pix_i.green < mn_d) mn_d = pix_i.green;
    if (pix_i.blue < mn_d) mn_d = pix_i.blue;
    delta_d = mx_d - mn_d;
    // ties go red, then green
    if (mx_d == pix_i.red) begin
      sec_d  = r2h_pkg::SecRed;
      diff_d = $signed({1'b0, pix_i.green}) - $signed({1'b0, pix_i.blue});
    end else if (mx_d == pix_i.green) begin
      sec_d  = r2h_pkg::SecGreen;
      diff_d = $signed({1'b0, pix_i.blue}) - $signed({1'b0, pix_i.red});
    end else begin
      sec_d  = r2h_pkg::SecBlue;
      diff_d = $signed({1'b0, pix_i.red}) - $signed({1'b0, pix_i.green});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s0) begin
      mx_q    <= mx_d;
      delta_q <= delta_d;
      diff_q  <= diff_d;
      sec_q   <= sec_d;
    end
  end

  // stage 1: numerators and reciprocal lookup
  logic [11:0] d12, diff12, num12;
  logic [16:0] num17, y17;
  logic [15:0] hue_num_d, sat_num_d;
  logic [15:0] d16;

  always_comb begin
    d12    = {4'b0, delta_q};
    diff12 = {{3{diff_q[8]}}, diff_q};
    // sector offset times delta plus the signed difference, mod 2^12
    case (sec_q)
      r2h_pkg::SecRed: begin
        if (diff_q[8]) num12 = (d12 << 2) + (d12 << 1) + diff12;
        else           num12 = diff12;
      end
      r2h_pkg::SecGreen: num12 = (d12 << 1) + diff12;
      r2h_pkg::SecBlue:  num12 = (d12 << 2) + diff12;
      default:           num12 = '0;
    endcase
    num17 = {5'b0, num12};
    // (255*num + 3*delta) / 3 = 85*num + delta, halved for the 2*delta divisor
    y17       = (num17 << 6) + (num17 << 4) + (num17 << 2) + num17 + {9'b0, delta_q};
    hue_num_d = y17[16:1];
    d16       = {8'b0, delta_q};
    // 255*delta + floor(max/2)
    sat_num_d = (d16 << 8) - d16 + {9'b0, mx_q[7:1]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      hue_num_o   <= hue_num_d;
      hue_den_o   <= delta_q;
      hue_recip_o <= recip_tbl[delta_q];
      hue_zero_o  <= (delta_q == '0);
      sat_num_o   <= sat_num_d;
      sat_den_o   <= mx_q;
      sat_recip_o <= recip_tbl[mx_q];
      sat_zero_o  <= (mx_q == '0);
    end
  end

endmodule

// File: sv/r2h_div.sv
// two-stage reciprocal divider: multiply estimate, then one-step correction
module r2h_div (
  input  logic                        clk_i,
  input  r2h_pkg::stage_en_t          en_i,
  input  logic [r2h_pkg::NumerW-1:0]  num_i,
  input  logic [r2h_pkg::ChanW-1:0]   den_i,
  input  logic [r2h_pkg::RecipW-1:0]  recip_i,
  input  logic                        zero_i,
  output logic [r2h_pkg::ChanW-1:0]   quot_o
);

  localparam int unsigned ProdW = r2h_pkg::NumerW + r2h_pkg::RecipW;

  // stage 0: estimate is the true quotient or one below it
  logic [ProdW-1:0]            prod;
  logic [r2h_pkg::ChanW-1:0]   est_q;
  logic [r2h_pkg::NumerW-1:0]  num_q;
  logic [r2h_pkg::ChanW-1:0]   den_q;
  logic                        zero_q;

  assign prod = ProdW'(num_i) * ProdW'(recip_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s0) begin
      est_q  <= prod[r2h_pkg::NumerW +: r2h_pkg::ChanW];
      num_q  <= num_i;
      den_q  <= den_i;
      zero_q <= zero_i;
    end
  end

  // stage 1: remainder check
  logic [r2h_pkg::NumerW-1:0] back, rem;
  logic [r2h_pkg::ChanW-1:0]  quot_d;

  always_comb begin
    back = r2h_pkg::NumerW'(est_q) * r2h_pkg::NumerW'(den_q);
    rem  = num_q - back;
    if (zero_q)                                  quot_d = '0;
    else if (rem >= r2h_pkg::NumerW'(den_q))     quot_d = est_q + 8'd1;
    else                                         quot_d = est_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      quot_o <= quot_d;
    end
  end

endmodule

// File: sv/rgb_to_hsv_converter.sv
// rgb to hsv converter top level: four-stage pipeline with per-stage flow control
//
//  channel  dir  payload          handshake
//  req      in   red/green/blue   req_valid_i / req_ready_o
//  res      out  hue/sat/bright   res_valid_o / res_ready_i
//
// one pixel per clock unless res_ready_i stalls the pipeline; each request passes through the stages in order
// stages: max/min, numerators + reciprocal lookup, 16x17 multiply, correction
// reset clears only the stage valid bits
// a stalled stage holds its data; empty stages upstream keep filling
module rgb_to_hsv_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  r2h_pkg::pix_req_t req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output r2h_pkg::hsv_res_t res_o
);

  localparam int unsigned NumStages = 4;

  logic [NumStages-1:0] valid_q, valid_d, en;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || res_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    if (en[0]) valid_d[0] = req_valid_i;
    else       valid_d[0] = valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) valid_d[k] = valid_q[k-1];
      else       valid_d[k] = valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign req_ready_o = en[0];
  assign res_valid_o = valid_q[NumStages-1];

  r2h_pkg::stage_en_t en_front, en_back;
  assign en_front = '{s0: en[0], s1: en[1]};
  assign en_back  = '{s0: en[2], s1: en[3]};

  logic [r2h_pkg::NumerW-1:0] hue_num, sat_num;
  logic [r2h_pkg::ChanW-1:0]  hue_den, sat_den;
  logic [r2h_pkg::RecipW-1:0] hue_recip, sat_recip;
  logic                       hue_zero, sat_zero;
  logic [r2h_pkg::ChanW-1:0]  hue_q, sat_q;

  r2h_prep u_prep (
    .clk_i       (clk_i),
    .en_i        (en_front),
    .pix_i       (req_i),
    .hue_num_o   (hue_num),
    .hue_den_o   (hue_den),
    .hue_recip_o (hue_recip),
    .hue_zero_o  (hue_zero),
    .sat_num_o   (sat_num),
    .sat_den_o   (sat_den),
    .sat_recip_o (sat_recip),
    .sat_zero_o  (sat_zero)
  );

  r2h_div u_div_hue (
    .clk_i   (clk_i),
    .en_i    (en_back),
    .num_i   (hue_num),
    .den_i   (hue_den),
    .recip_i (hue_recip),
    .zero_i  (hue_zero),
    .quot_o  (hue_q)
  );

  r2h_div u_div_sat (
    .clk_i   (clk_i),
    .en_i    (en_back),
    .num_i   (sat_num),
    .den_i   (sat_den),
    .recip_i (sat_recip),
    .zero_i  (sat_zero),
    .quot_o  (sat_q)
  );

  // brightness is the saturation divisor, carried alongside the divider stages
  logic [r2h_pkg::ChanW-1:0] bright_c_q, bright_d_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      bright_c_q <= sat_den;
    end
    if (en[3]) begin
      bright_d_q <= bright_c_q;
    end
  end

  assign res_o = '{hue: hue_q, saturation: sat_q, brightness: bright_d_q};

endmodule
